// ----- hdl/mtpe_pkg.sv -----
`timescale 1ns / 1ps
package mtpe_pkg;

  localparam int MAX_ITEMS_DEF = 256;

  localparam logic [7:0] ACK_ACCEPTED    = 8'd0;
  localparam logic [7:0] ACK_INVALID_SEQ = 8'd13;

  typedef enum logic [3:0] {
    CMD_START_READ  = 4'd0,
    CMD_START_WRITE = 4'd1,
    CMD_START_CLEAR = 4'd2,
    CMD_CANCEL      = 4'd3,
    CMD_RX_COUNT    = 4'd4,
    CMD_RX_ITEM     = 4'd5,
    CMD_RX_REQUEST  = 4'd6,
    CMD_RX_ACK      = 4'd7,
    CMD_TICK        = 4'd8
  } cmd_e;

  typedef enum logic [2:0] {
    KIND_REQ_LIST   = 3'd0,
    KIND_REQ_ITEM   = 3'd1,
    KIND_SEND_COUNT = 3'd2,
    KIND_SEND_ITEM  = 3'd3,
    KIND_SEND_ACK   = 3'd4,
    KIND_CLEAR_ALL  = 3'd5,
    KIND_STORED     = 3'd6,
    KIND_DONE       = 3'd7
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_RANGE    = 3'd1,
    ERR_ACK      = 3'd2,
    ERR_MISSING  = 3'd3,
    ERR_RETRY    = 3'd4,
    ERR_CAPACITY = 3'd5
  } err_e;

  typedef enum logic [2:0] {
    CFG_PLAN_TYPE    = 3'd0,
    CFG_QUIRKS       = 3'd1,
    CFG_ACK_TIMEOUT  = 3'd2,
    CFG_ITEM_TIMEOUT = 3'd3,
    CFG_MAX_RETRIES  = 3'd4
  } cfg_e;

  typedef struct packed {
    logic [15:0] a;
    logic [15:0] b;
  } alu_req_t;

  typedef struct packed {
    logic        lt;
    logic        le;
    logic [15:0] diff;
  } alu_rsp_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] seq;
    logic [8:0] cnt;
    logic       ok;
    err_e       err;
    logic       last;
  } res_t;

endpackage

// ----- hdl/mtpe_ram.sv -----
`timescale 1ns / 1ps
module mtpe_ram #(
  parameter int W = 1,
  parameter int D = 256
) (
  input  logic                                clk_i,
  input  logic                                we_i,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0] waddr_i,
  input  logic [W-1:0]                        wdata_i,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0] raddr_i,
  output logic [W-1:0]                        rdata_o
);
  logic [W-1:0] mem_q [D];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

// ----- hdl/mtpe_alu.sv -----
`timescale 1ns / 1ps
module mtpe_alu (
  input  mtpe_pkg::alu_req_t req_i,
  output mtpe_pkg::alu_rsp_t rsp_o
);
  import mtpe_pkg::*;

  // shared compare / subtract used by the command, scan and request-check steps of the sequencer
  assign rsp_o.lt   = req_i.a < req_i.b;
  assign rsp_o.le   = req_i.a <= req_i.b;
  assign rsp_o.diff = req_i.a - req_i.b;
endmodule

// ----- hdl/mission_transfer_protocol_engine_top.sv -----
`timescale 1ns / 1ps
// Ground-side mission list transfer engine (read, write, clear-all) with tick timeout,
// retransmission and retry limit. An input item is taken only while in_stall_o is low;
// a command is decoded in ST_EXEC and each result is handed on in ST_EMIT, which waits
// while the output is stalled. A newly stored item also walks the pending map from the
// lowest unread index through ST_SCAN and ST_SCAN_CHK (registered-read map memory).
// Every end of a transaction clears the map entries that were in use, one entry per
// cycle, and after reset the whole map is cleared before the first item is taken.
module mission_transfer_protocol_engine_top #(
  parameter int MAX_ITEMS = mtpe_pkg::MAX_ITEMS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [3:0]  command_i,
  input  logic [7:0]  mission_type_i,
  input  logic [15:0] seq_i,
  input  logic [15:0] count_i,
  input  logic [7:0]  ack_type_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  kind_o,
  output logic [7:0]  seq_out_o,
  output logic [8:0]  count_out_o,
  output logic        success_o,
  output logic [2:0]  error_code_o,
  output logic        last_o
);
  import mtpe_pkg::*;

  localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CW = $clog2(MAX_ITEMS + 1);

  typedef enum logic [3:0] {
    ST_CLR, ST_IDLE, ST_EXEC, ST_ITEM_CHK, ST_SCAN, ST_SCAN_CHK,
    ST_REQ_CHK, ST_FIN, ST_EMIT
  } st_e;

  typedef enum logic [2:0] {
    PH_IDLE, PH_WCOUNT, PH_WITEM, PH_WREQ, PH_WCLEAR
  } ph_e;

  typedef enum logic [1:0] {
    TR_NONE, TR_READ, TR_WRITE, TR_CLEAR
  } tr_e;

  st_e         state_q, state_d, ret_q, ret_d;
  ph_e         phase_q, phase_d;
  tr_e         trans_q, trans_d;
  logic [7:0]  retry_q, retry_d;
  logic [15:0] timer_q, timer_d;
  logic        trun_q, trun_d;
  logic [CW-1:0] rtotal_q, rtotal_d, wtotal_q, wtotal_d, wleft_q, wleft_d;
  logic [CW-1:0] low_q, low_d, clr_q, clr_d, clr_end_q, clr_end_d;
  logic [3:0]  cmd_q, cmd_d;
  logic [7:0]  mtype_q, mtype_d, ackt_q, ackt_d;
  logic [15:0] seq_q, seq_d, cnt_q, cnt_d;
  res_t        res_q, res_d, out_q, out_d;
  logic        out_valid_q, out_valid_d;
  logic        fin_ok_q, fin_ok_d;
  err_e        fin_err_q, fin_err_d;
  logic [7:0]  plan_q, plan_d, maxr_q, maxr_d;
  logic        quirk_q, quirk_d;
  logic [15:0] ackto_q, ackto_d, itemto_q, itemto_d;

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;
  logic          ram_we, ram_wdata, ram_rdata;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic          busy, msg_ok;
  logic [15:0]   low_w, wtot_w;
  logic [CW-1:0] span;

  mtpe_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  mtpe_ram #(.W(1), .D(MAX_ITEMS)) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  function automatic res_t mk_res(kind_e k, logic [7:0] s, logic [8:0] c, logic ok,
                                  err_e e, logic l);
    res_t r;
    r.kind = k;
    r.seq  = s;
    r.cnt  = c;
    r.ok   = ok;
    r.err  = e;
    r.last = l;
    return r;
  endfunction

  assign busy   = trans_q != TR_NONE;
  assign msg_ok = busy && (mtype_q == plan_q);
  assign low_w  = 16'(low_q);
  assign wtot_w = 16'(wtotal_q);

  always_comb begin
    case (trans_q)
      TR_READ:  span = rtotal_q;
      TR_WRITE: span = wtotal_q;
      default:  span = '0;
    endcase
  end

  always_comb begin
    alu_req = '0;
    case (state_q)
      ST_EXEC: begin
        case (cmd_q)
          CMD_START_WRITE, CMD_RX_COUNT: begin
            alu_req.a = cnt_q;
            alu_req.b = 16'(MAX_ITEMS);
          end
          CMD_RX_ITEM: begin
            alu_req.a = seq_q;
            alu_req.b = 16'(rtotal_q);
          end
          CMD_RX_REQUEST: begin
            alu_req.a = seq_q;
            alu_req.b = 16'(wtotal_q);
          end
          CMD_TICK: begin
            alu_req.a = timer_q;
            alu_req.b = 16'd1;
          end
          default: alu_req = '0;
        endcase
      end
      ST_SCAN: begin
        alu_req.a = low_w;
        alu_req.b = 16'(rtotal_q);
      end
      ST_REQ_CHK: begin
        alu_req.a = 16'(wleft_q);
        alu_req.b = 16'd1;
      end
      default: alu_req = '0;
    endcase
  end

  assign ram_raddr = (state_q == ST_SCAN) ? low_q[AW-1:0] : seq_q[AW-1:0];

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = seq_q[AW-1:0];
    ram_wdata = 1'b1;
    if (state_q == ST_CLR && clr_q != clr_end_q) begin
      ram_we    = 1'b1;
      ram_waddr = clr_q[AW-1:0];
      ram_wdata = 1'b0;
    end else if (state_q == ST_ITEM_CHK && !ram_rdata) begin
      ram_we = 1'b1;
    end else if (state_q == ST_REQ_CHK) begin
      ram_we = 1'b1;
    end
  end

  always_comb begin
    state_d     = state_q;
    ret_d       = ret_q;
    phase_d     = phase_q;
    trans_d     = trans_q;
    retry_d     = retry_q;
    timer_d     = timer_q;
    trun_d      = trun_q;
    rtotal_d    = rtotal_q;
    wtotal_d    = wtotal_q;
    wleft_d     = wleft_q;
    low_d       = low_q;
    clr_d       = clr_q;
    clr_end_d   = clr_end_q;
    cmd_d       = cmd_q;
    mtype_d     = mtype_q;
    seq_d       = seq_q;
    cnt_d       = cnt_q;
    ackt_d      = ackt_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    fin_ok_d    = fin_ok_q;
    fin_err_d   = fin_err_q;
    plan_d      = plan_q;
    quirk_d     = quirk_q;
    ackto_d     = ackto_q;
    itemto_d    = itemto_q;
    maxr_d      = maxr_q;

    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PLAN_TYPE:    plan_d   = cfg_data_i[7:0];
        CFG_QUIRKS:       quirk_d  = cfg_data_i[0];
        CFG_ACK_TIMEOUT:  ackto_d  = cfg_data_i;
        CFG_ITEM_TIMEOUT: itemto_d = cfg_data_i;
        CFG_MAX_RETRIES:  maxr_d   = cfg_data_i[7:0];
        default: ;
      endcase
    end

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_CLR: begin
        if (clr_q == clr_end_q) begin
          state_d = ST_IDLE;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_d   = command_i;
          mtype_d = mission_type_i;
          seq_d   = seq_i;
          cnt_d   = count_i;
          ackt_d  = ack_type_i;
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d = ST_IDLE;
        case (cmd_q)
          CMD_START_READ: begin
            if (!busy) begin
              retry_d  = '0;
              trans_d  = TR_READ;
              rtotal_d = '0;
              phase_d  = PH_WCOUNT;
              timer_d  = ackto_q;
              trun_d   = 1'b1;
              res_d    = mk_res(KIND_REQ_LIST, '0, '0, 1'b0, ERR_NONE, 1'b1);
              ret_d    = ST_IDLE;
              state_d  = ST_EMIT;
            end
          end
          CMD_START_WRITE: begin
            if (!busy) begin
              retry_d = '0;
              ret_d   = ST_IDLE;
              state_d = ST_EMIT;
              if (!alu_rsp.le) begin
                res_d = mk_res(KIND_DONE, '0, '0, 1'b0, ERR_CAPACITY, 1'b1);
              end else begin
                trans_d  = TR_WRITE;
                wtotal_d = cnt_q[CW-1:0];
                wleft_d  = cnt_q[CW-1:0];
                phase_d  = PH_WREQ;
                timer_d  = ackto_q;
                trun_d   = 1'b1;
                res_d    = mk_res(KIND_SEND_COUNT, '0, cnt_q[8:0], 1'b0, ERR_NONE, 1'b1);
              end
            end
          end
          CMD_START_CLEAR: begin
            if (!busy) begin
              retry_d = '0;
              trans_d = TR_CLEAR;
              phase_d = PH_WCLEAR;
              timer_d = ackto_q;
              trun_d  = 1'b1;
              res_d   = mk_res(KIND_CLEAR_ALL, '0, '0, 1'b0, ERR_NONE, 1'b1);
              ret_d   = ST_IDLE;
              state_d = ST_EMIT;
            end
          end
          CMD_CANCEL: begin
            if (busy) begin
              timer_d   = '0;
              trun_d    = 1'b0;
              phase_d   = PH_IDLE;
              trans_d   = TR_NONE;
              clr_d     = '0;
              clr_end_d = span;
              state_d   = ST_CLR;
            end
          end
          CMD_TICK: begin
            if (busy && trun_q) begin
              if (!alu_rsp.le) begin
                timer_d = alu_rsp.diff;
              end else begin
                timer_d = '0;
                trun_d  = 1'b0;
                if (retry_q >= maxr_q) begin
                  fin_ok_d  = 1'b0;
                  fin_err_d = ERR_RETRY;
                  state_d   = ST_FIN;
                end else begin
                  // resend the message of the current wait (a write with requests seen ends as missing)
                  retry_d = retry_q + 1'b1;
                  ret_d   = ST_IDLE;
                  case (phase_q)
                    PH_WCOUNT: begin
                      res_d   = mk_res(KIND_REQ_LIST, '0, '0, 1'b0, ERR_NONE, 1'b1);
                      timer_d = ackto_q;
                      trun_d  = 1'b1;
                      state_d = ST_EMIT;
                    end
                    PH_WITEM: begin
                      res_d   = mk_res(KIND_REQ_ITEM, low_w[7:0], '0, 1'b0, ERR_NONE, 1'b1);
                      timer_d = itemto_q;
                      trun_d  = 1'b1;
                      state_d = ST_EMIT;
                    end
                    PH_WREQ: begin
                      if (wleft_q == wtotal_q) begin
                        res_d   = mk_res(KIND_SEND_COUNT, '0, wtot_w[8:0], 1'b0, ERR_NONE,
                                         1'b1);
                        timer_d = ackto_q;
                        trun_d  = 1'b1;
                        state_d = ST_EMIT;
                      end else begin
                        fin_ok_d  = 1'b0;
                        fin_err_d = ERR_MISSING;
                        state_d   = ST_FIN;
                      end
                    end
                    PH_WCLEAR: begin
                      res_d   = mk_res(KIND_CLEAR_ALL, '0, '0, 1'b0, ERR_NONE, 1'b1);
                      timer_d = ackto_q;
                      trun_d  = 1'b1;
                      state_d = ST_EMIT;
                    end
                    default: state_d = ST_IDLE;
                  endcase
                end
              end
            end
          end
          CMD_RX_COUNT: begin
            if (msg_ok && phase_q == PH_WCOUNT) begin
              timer_d = '0;
              trun_d  = 1'b0;
              retry_d = '0;
              if (cnt_q == 16'd0) begin
                fin_ok_d  = 1'b1;
                fin_err_d = ERR_NONE;
                res_d     = mk_res(KIND_SEND_ACK, '0, '0, 1'b0, ERR_NONE, 1'b0);
                ret_d     = ST_FIN;
                state_d   = ST_EMIT;
              end else if (!alu_rsp.le) begin
                fin_ok_d  = 1'b0;
                fin_err_d = ERR_CAPACITY;
                state_d   = ST_FIN;
              end else begin
                rtotal_d = cnt_q[CW-1:0];
                low_d    = '0;
                phase_d  = PH_WITEM;
                timer_d  = itemto_q;
                trun_d   = 1'b1;
                res_d    = mk_res(KIND_REQ_ITEM, '0, '0, 1'b0, ERR_NONE, 1'b1);
                ret_d    = ST_IDLE;
                state_d  = ST_EMIT;
              end
            end
          end
          CMD_RX_ITEM: begin
            if (msg_ok && phase_q == PH_WITEM) begin
              timer_d = '0;
              trun_d  = 1'b0;
              if (alu_rsp.lt) begin
                state_d = ST_ITEM_CHK;
              end else begin
                timer_d = itemto_q;
                trun_d  = 1'b1;
              end
            end
          end
          CMD_RX_REQUEST: begin
            if (msg_ok && phase_q == PH_WREQ) begin
              timer_d = '0;
              trun_d  = 1'b0;
              if (!alu_rsp.lt) begin
                fin_ok_d  = 1'b0;
                fin_err_d = ERR_RANGE;
                state_d   = ST_FIN;
              end else begin
                state_d = ST_REQ_CHK;
              end
            end
          end
          CMD_RX_ACK: begin
            if (msg_ok && !(quirk_q && ackt_q == ACK_INVALID_SEQ)) begin
              timer_d = '0;
              trun_d  = 1'b0;
              if (phase_q == PH_WCLEAR) begin
                fin_ok_d  = ackt_q == ACK_ACCEPTED;
                fin_err_d = (ackt_q == ACK_ACCEPTED) ? ERR_NONE : ERR_ACK;
                state_d   = ST_FIN;
              end else if (phase_q == PH_WREQ) begin
                state_d = ST_FIN;
                if (ackt_q != ACK_ACCEPTED) begin
                  fin_ok_d  = 1'b0;
                  fin_err_d = ERR_ACK;
                end else if (wleft_q == '0) begin
                  fin_ok_d  = 1'b1;
                  fin_err_d = ERR_NONE;
                end else begin
                  fin_ok_d  = 1'b0;
                  fin_err_d = ERR_MISSING;
                end
              end
            end
          end
          default: state_d = ST_IDLE;
        endcase
      end
      ST_ITEM_CHK: begin
        if (!ram_rdata) begin
          retry_d = '0;
          res_d   = mk_res(KIND_STORED, seq_q[7:0], '0, 1'b0, ERR_NONE, 1'b0);
          ret_d   = ST_SCAN;
          state_d = ST_EMIT;
        end else begin
          timer_d = itemto_q;
          trun_d  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (!alu_rsp.lt) begin
          // all items in: acknowledge and close
          fin_ok_d  = 1'b1;
          fin_err_d = ERR_NONE;
          res_d     = mk_res(KIND_SEND_ACK, '0, '0, 1'b0, ERR_NONE, 1'b0);
          ret_d     = ST_FIN;
          state_d   = ST_EMIT;
        end else begin
          state_d = ST_SCAN_CHK;
        end
      end
      ST_SCAN_CHK: begin
        if (ram_rdata) begin
          low_d   = low_q + 1'b1;
          state_d = ST_SCAN;
        end else begin
          timer_d = itemto_q;
          trun_d  = 1'b1;
          res_d   = mk_res(KIND_REQ_ITEM, low_w[7:0], '0, 1'b0, ERR_NONE, 1'b1);
          ret_d   = ST_IDLE;
          state_d = ST_EMIT;
        end
      end
      ST_REQ_CHK: begin
        if (!ram_rdata) begin
          wleft_d = alu_rsp.diff[CW-1:0];
        end
        timer_d = ackto_q;
        trun_d  = 1'b1;
        res_d   = mk_res(KIND_SEND_ITEM, seq_q[7:0], '0, 1'b0, ERR_NONE, 1'b1);
        ret_d   = ST_IDLE;
        state_d = ST_EMIT;
      end
      ST_FIN: begin
        timer_d   = '0;
        trun_d    = 1'b0;
        phase_d   = PH_IDLE;
        trans_d   = TR_NONE;
        clr_d     = '0;
        clr_end_d = span;
        res_d     = mk_res(KIND_DONE, '0, '0, fin_ok_q, fin_err_q, 1'b1);
        ret_d     = ST_CLR;
        state_d   = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          state_d     = ret_q;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      ret_q       <= ST_IDLE;
      phase_q     <= PH_IDLE;
      trans_q     <= TR_NONE;
      retry_q     <= '0;
      timer_q     <= '0;
      trun_q      <= 1'b0;
      rtotal_q    <= '0;
      wtotal_q    <= '0;
      wleft_q     <= '0;
      low_q       <= '0;
      clr_q       <= '0;
      clr_end_q   <= CW'(MAX_ITEMS);
      cmd_q       <= '0;
      mtype_q     <= '0;
      seq_q       <= '0;
      cnt_q       <= '0;
      ackt_q      <= '0;
      res_q       <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
      fin_ok_q    <= 1'b0;
      fin_err_q   <= ERR_NONE;
      plan_q      <= 8'd0;
      quirk_q     <= 1'b0;
      ackto_q     <= 16'd1000;
      itemto_q    <= 16'd250;
      maxr_q      <= 8'd5;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      phase_q     <= phase_d;
      trans_q     <= trans_d;
      retry_q     <= retry_d;
      timer_q     <= timer_d;
      trun_q      <= trun_d;
      rtotal_q    <= rtotal_d;
      wtotal_q    <= wtotal_d;
      wleft_q     <= wleft_d;
      low_q       <= low_d;
      clr_q       <= clr_d;
      clr_end_q   <= clr_end_d;
      cmd_q       <= cmd_d;
      mtype_q     <= mtype_d;
      seq_q       <= seq_d;
      cnt_q       <= cnt_d;
      ackt_q      <= ackt_d;
      res_q       <= res_d;
      out_q       <= out_d;
      out_valid_q <= out_valid_d;
      fin_ok_q    <= fin_ok_d;
      fin_err_q   <= fin_err_d;
      plan_q      <= plan_d;
      quirk_q     <= quirk_d;
      ackto_q     <= ackto_d;
      itemto_q    <= itemto_d;
      maxr_q      <= maxr_d;
    end
  end

  assign in_stall_o   = state_q != ST_IDLE;
  assign out_valid_o  = out_valid_q;
  assign kind_o       = out_q.kind;
  assign seq_out_o    = out_q.seq;
  assign count_out_o  = out_q.cnt;
  assign success_o    = out_q.ok;
  assign error_code_o = out_q.err;
  assign last_o       = out_q.last;

`ifndef SYNTH
  a_busy_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (trans_q != TR_NONE) == (phase_q != PH_IDLE))
    else $error("transaction and phase disagree");
  a_timer_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    trun_q |-> (trans_q != TR_NONE))
    else $error("timer running with no transaction");
  a_wleft: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (trans_q == TR_WRITE) |-> (wleft_q <= wtotal_q))
    else $error("write pending count above write total");
  a_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_WITEM && state_q == ST_IDLE) |-> (low_q < rtotal_q))
    else $error("lowest unread index out of range while waiting for an item");
`endif
endmodule

// ----- sim/tb_mission_transfer_protocol_engine_top.sv -----
`timescale 1ns / 1ps
module tb_mission_transfer_protocol_engine_top;
  import mtpe_pkg::*;

  localparam int NMAX       = 256;
  localparam int IDLE_WAIT  = 1200;
  localparam int STALL_LIMIT = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [3:0]  command_i = '0;
  logic [7:0]  mission_type_i = '0;
  logic [15:0] seq_i = '0;
  logic [15:0] count_i = '0;
  logic [7:0]  ack_type_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  kind_o;
  logic [7:0]  seq_out_o;
  logic [8:0]  count_out_o;
  logic        success_o;
  logic [2:0]  error_code_o;
  logic        last_o;

  mission_transfer_protocol_engine_top u_top (.*);

  always #2 clk_i = ~clk_i;

  // engine state as seen from outside
  logic [7:0]  m_plan;
  logic        m_quirks;
  logic [15:0] m_ack_to, m_item_to;
  logic [7:0]  m_max_retry;
  typedef enum logic [2:0] {PH_IDLE, PH_WAIT_COUNT, PH_WAIT_ITEM, PH_WAIT_REQUEST,
                            PH_WAIT_CLEAR} phase_e;
  typedef enum logic [1:0] {TR_NONE, TR_READ, TR_WRITE, TR_CLEAR} trans_e;
  phase_e      m_phase;
  trans_e      m_trans;
  logic [7:0]  m_retry;
  logic [15:0] m_timer;
  logic        m_timer_on;
  logic [NMAX-1:0] m_rd_pend, m_wr_pend;
  logic [8:0]  m_rd_total, m_wr_total;

  res_t expected_msgs[$];
  int   n_items, n_msgs, n_errors;
  bit   no_idle, long_hold_req;
  int   hold_left, out_burst, quiet_cycles;

  task automatic push_msg(kind_e k, logic [7:0] s, logic [8:0] c, logic ok, err_e e);
    res_t r;
    r.kind = k; r.seq = s; r.cnt = c; r.ok = ok; r.err = e; r.last = 1'b0;
    expected_msgs.push_back(r);
  endtask

  task automatic timer_go(logic [15:0] t);
    m_timer = t; m_timer_on = 1'b1;
  endtask

  task automatic end_transfer(logic ok, err_e e);
    m_timer = '0; m_timer_on = 1'b0;
    m_rd_pend = '0; m_wr_pend = '0;
    m_phase = PH_IDLE; m_trans = TR_NONE;
    push_msg(KIND_DONE, 8'd0, 9'd0, ok, e);
  endtask

  function automatic int lowest_unread();
    for (int i = 0; i < m_rd_total && i < NMAX; i++)
      if (m_rd_pend[i]) return i;
    return NMAX;
  endfunction

  function automatic int writes_left();
    int n;
    n = 0;
    for (int i = 0; i < m_wr_total && i < NMAX; i++) n += m_wr_pend[i];
    return n;
  endfunction

  task automatic request_next();
    int i;
    i = lowest_unread();
    if (i >= NMAX) begin
      push_msg(KIND_SEND_ACK, 8'd0, 9'd0, 1'b0, ERR_NONE);
      end_transfer(1'b1, ERR_NONE);
    end else begin
      push_msg(KIND_REQ_ITEM, i[7:0], 9'd0, 1'b0, ERR_NONE);
      m_phase = PH_WAIT_ITEM;
      timer_go(m_item_to);
    end
  endtask

  task automatic expire();
    int i;
    m_timer = '0; m_timer_on = 1'b0;
    if (m_retry >= m_max_retry) begin
      end_transfer(1'b0, ERR_RETRY);
      return;
    end
    m_retry++;
    case (m_phase)
      PH_WAIT_COUNT: begin
        push_msg(KIND_REQ_LIST, 8'd0, 9'd0, 1'b0, ERR_NONE);
        timer_go(m_ack_to);
      end
      PH_WAIT_ITEM: begin
        i = lowest_unread();
        if (i < NMAX) begin
          push_msg(KIND_REQ_ITEM, i[7:0], 9'd0, 1'b0, ERR_NONE);
          timer_go(m_item_to);
        end
      end
      PH_WAIT_REQUEST: begin
        if (writes_left() == m_wr_total) begin
          push_msg(KIND_SEND_COUNT, 8'd0, m_wr_total, 1'b0, ERR_NONE);
          timer_go(m_ack_to);
        end else begin
          end_transfer(1'b0, ERR_MISSING);
        end
      end
      PH_WAIT_CLEAR: begin
        push_msg(KIND_CLEAR_ALL, 8'd0, 9'd0, 1'b0, ERR_NONE);
        timer_go(m_ack_to);
      end
      default: ;
    endcase
  endtask

  task automatic predict_engine(logic [3:0] cmd, logic [7:0] mt, logic [15:0] sq,
                                logic [15:0] cn, logic [7:0] ak);
    bit busy;
    int start_n;
    busy = (m_trans != TR_NONE);
    start_n = expected_msgs.size();
    if (cmd <= CMD_START_CLEAR) begin
      if (!busy) begin
        m_retry = '0;
        if (cmd == CMD_START_READ) begin
          m_trans = TR_READ; m_rd_pend = '0; m_rd_total = '0;
          push_msg(KIND_REQ_LIST, 8'd0, 9'd0, 1'b0, ERR_NONE);
          m_phase = PH_WAIT_COUNT;
          timer_go(m_ack_to);
        end else if (cmd == CMD_START_WRITE) begin
          if (cn > NMAX) begin
            push_msg(KIND_DONE, 8'd0, 9'd0, 1'b0, ERR_CAPACITY);
          end else begin
            m_trans = TR_WRITE; m_wr_total = cn[8:0]; m_wr_pend = '0;
            for (int i = 0; i < cn; i++) m_wr_pend[i] = 1'b1;
            push_msg(KIND_SEND_COUNT, 8'd0, cn[8:0], 1'b0, ERR_NONE);
            m_phase = PH_WAIT_REQUEST;
            timer_go(m_ack_to);
          end
        end else begin
          m_trans = TR_CLEAR;
          push_msg(KIND_CLEAR_ALL, 8'd0, 9'd0, 1'b0, ERR_NONE);
          m_phase = PH_WAIT_CLEAR;
          timer_go(m_ack_to);
        end
      end
    end else if (cmd == CMD_CANCEL) begin
      if (busy) begin
        m_timer = '0; m_timer_on = 1'b0; m_rd_pend = '0; m_wr_pend = '0;
        m_phase = PH_IDLE; m_trans = TR_NONE;
      end
    end else if (cmd == CMD_TICK) begin
      if (busy && m_timer_on) begin
        if (m_timer <= 1) expire();
        else m_timer--;
      end
    end else if (cmd <= CMD_RX_ACK && busy && mt == m_plan) begin
      case (cmd)
        CMD_RX_COUNT: if (m_phase == PH_WAIT_COUNT) begin
          m_timer = '0; m_timer_on = 1'b0; m_retry = '0;
          if (cn == 0) begin
            push_msg(KIND_SEND_ACK, 8'd0, 9'd0, 1'b0, ERR_NONE);
            end_transfer(1'b1, ERR_NONE);
          end else if (cn > NMAX) begin
            end_transfer(1'b0, ERR_CAPACITY);
          end else begin
            m_rd_total = cn[8:0];
            for (int i = 0; i < cn; i++) m_rd_pend[i] = 1'b1;
            request_next();
          end
        end
        CMD_RX_ITEM: if (m_phase == PH_WAIT_ITEM) begin
          m_timer = '0; m_timer_on = 1'b0;
          if (sq < m_rd_total && sq < NMAX && m_rd_pend[sq[7:0]]) begin
            m_rd_pend[sq[7:0]] = 1'b0;
            push_msg(KIND_STORED, sq[7:0], 9'd0, 1'b0, ERR_NONE);
            m_retry = '0;
            request_next();
          end else begin
            timer_go(m_item_to);
          end
        end
        CMD_RX_REQUEST: if (m_phase == PH_WAIT_REQUEST) begin
          m_timer = '0; m_timer_on = 1'b0;
          if (sq >= m_wr_total || sq >= NMAX) begin
            end_transfer(1'b0, ERR_RANGE);
          end else begin
            m_wr_pend[sq[7:0]] = 1'b0;
            push_msg(KIND_SEND_ITEM, sq[7:0], 9'd0, 1'b0, ERR_NONE);
            timer_go(m_ack_to);
          end
        end
        default: if (!(m_quirks && ak == ACK_INVALID_SEQ)) begin
          m_timer = '0; m_timer_on = 1'b0;
          if (m_phase == PH_WAIT_CLEAR) begin
            if (ak == ACK_ACCEPTED) end_transfer(1'b1, ERR_NONE);
            else end_transfer(1'b0, ERR_ACK);
          end else if (m_phase == PH_WAIT_REQUEST) begin
            if (ak != ACK_ACCEPTED) end_transfer(1'b0, ERR_ACK);
            else if (writes_left() == 0) end_transfer(1'b1, ERR_NONE);
            else end_transfer(1'b0, ERR_MISSING);
          end
        end
      endcase
    end
    if (expected_msgs.size() > start_n)
      expected_msgs[expected_msgs.size()-1].last = 1'b1;
  endtask

  task automatic send_item(logic [3:0] cmd, logic [7:0] mt, logic [15:0] sq,
                           logic [15:0] cn, logic [7:0] ak);
    if (!no_idle && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i <= cmd; mission_type_i <= mt; seq_i <= sq; count_i <= cn; ack_type_i <= ak;
    do @(posedge clk_i); while (in_stall_o);
    predict_engine(cmd, mt, sq, cn, ak);
    n_items++;
  endtask

  // message for the current plan type
  task automatic send_msg(cmd_e cmd, logic [15:0] sq, logic [15:0] cn, logic [7:0] ak);
    send_item(cmd, m_plan, sq, cn, ak);
  endtask

  task automatic send_noise();
    send_item(4'($urandom), 8'($urandom), 16'($urandom), 16'($urandom), 8'($urandom));
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    wait (expected_msgs.size() == 0);
    repeat (IDLE_WAIT) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_e idx, logic [15:0] val);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_PLAN_TYPE:    m_plan = val[7:0];
      CFG_QUIRKS:       m_quirks = val[0];
      CFG_ACK_TIMEOUT:  m_ack_to = val;
      CFG_ITEM_TIMEOUT: m_item_to = val;
      default:          m_max_retry = val[7:0];
    endcase
  endtask

  task automatic set_regs(logic [7:0] plan, logic q, logic [15:0] ato, logic [15:0] ito,
                          logic [7:0] mr);
    wait_drained();
    write_reg(CFG_PLAN_TYPE, {8'd0, plan});
    write_reg(CFG_QUIRKS, {15'd0, q});
    write_reg(CFG_ACK_TIMEOUT, ato);
    write_reg(CFG_ITEM_TIMEOUT, ito);
    write_reg(CFG_MAX_RETRIES, {8'd0, mr});
  endtask

  // results: checked in order; random stall bursts (none when no_idle), a long hold on request
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      if (expected_msgs.size() == 0) begin
        $display("%0t: unexpected result kind=%0d seq=%0d", $time, kind_o, seq_out_o);
        n_errors++;
      end else begin
        res_t e;
        e = expected_msgs.pop_front();
        n_msgs++;
        if (kind_o !== e.kind || seq_out_o !== e.seq || count_out_o !== e.cnt ||
            success_o !== e.ok || error_code_o !== e.err || last_o !== e.last) begin
          $display("%0t: mismatch expected kind=%0d seq=%0d cnt=%0d ok=%0d err=%0d last=%0d",
                   $time, e.kind, e.seq, e.cnt, e.ok, e.err, e.last);
          $display("%0t:          actual kind=%0d seq=%0d cnt=%0d ok=%0d err=%0d last=%0d",
                   $time, kind_o, seq_out_o, count_out_o, success_o, error_code_o, last_o);
          n_errors++;
        end
      end
    end
    if (long_hold_req) begin
      long_hold_req = 1'b0;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (no_idle) begin
      out_stall_i <= 1'b0;
    end else if (out_burst > 0) begin
      out_burst--;
      out_stall_i <= 1'b1;
    end else if ($urandom_range(0, 9) == 0) begin
      out_burst = $urandom_range(0, 17);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: watchdog expired", $time);
      $display("Verification failed");
      $finish;
    end
  end

  task automatic test_directed();
    set_regs(8'hA5, 1'b1, 16'd2, 16'd1, 8'd1);
    send_msg(CMD_TICK, 0, 0, 0);                 // idle messages drop
    send_msg(CMD_RX_COUNT, 0, 3, 0);
    send_item(4'd15, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF);
    send_msg(CMD_START_WRITE, 0, 16'd257, 0);    // over capacity
    send_msg(CMD_START_WRITE, 0, 0, 0);
    send_msg(CMD_RX_ACK, 0, 0, ACK_ACCEPTED);
    send_msg(CMD_START_READ, 0, 0, 0);
    send_msg(CMD_START_READ, 0, 0, 0);           // busy start
    send_msg(CMD_RX_ACK, 0, 0, ACK_ACCEPTED);    // stray ack
    send_msg(CMD_RX_COUNT, 0, 16'hFFFF, 0);
    send_msg(CMD_START_READ, 0, 0, 0);
    send_msg(CMD_RX_COUNT, 0, 0, 0);             // empty read
    send_msg(CMD_START_READ, 0, 0, 0);
    send_msg(CMD_RX_COUNT, 0, 3, 0);
    send_msg(CMD_RX_ITEM, 16'hFFFF, 0, 0);
    send_msg(CMD_RX_ITEM, 0, 0, 0);
    send_msg(CMD_RX_ITEM, 0, 0, 0);              // duplicate
    send_item(CMD_RX_ITEM, 8'h00, 16'd1, 0, 0);  // wrong plan type
    send_msg(CMD_TICK, 0, 0, 0);                 // resend request
    send_msg(CMD_RX_ITEM, 2, 0, 0);
    send_msg(CMD_RX_ITEM, 1, 0, 0);
    send_msg(CMD_START_CLEAR, 0, 0, 0);
    send_msg(CMD_RX_ACK, 0, 0, ACK_INVALID_SEQ);
    send_msg(CMD_RX_ACK, 0, 0, 8'hFF);
    send_msg(CMD_START_WRITE, 0, 2, 0);
    send_msg(CMD_RX_REQUEST, 5, 0, 0);           // out of range
    send_msg(CMD_START_WRITE, 0, 3, 0);
    send_msg(CMD_RX_REQUEST, 0, 0, 0);
    send_msg(CMD_TICK, 0, 0, 0);
    send_msg(CMD_TICK, 0, 0, 0);                 // missing requests
    send_msg(CMD_START_CLEAR, 0, 0, 0);
    send_msg(CMD_CANCEL, 0, 0, 0);
    send_msg(CMD_CANCEL, 0, 0, 0);
  endtask

  task automatic test_retry_limit();
    set_regs(8'hFF, 1'b0, 16'd1, 16'd1, 8'd0);
    send_msg(CMD_START_CLEAR, 0, 0, 0);
    send_msg(CMD_TICK, 0, 0, 0);
    send_msg(CMD_START_READ, 0, 0, 0);
    send_msg(CMD_TICK, 0, 0, 0);
    send_msg(CMD_RX_ACK, 0, 0, ACK_INVALID_SEQ);
  endtask

  task automatic run_transfer();
    int sel, n, steps;
    sel = $urandom_range(0, 9);
    if (sel < 4) begin
      send_msg(CMD_START_READ, 0, 0, 0);
      if ($urandom_range(0, 3) == 0) send_msg(CMD_TICK, 0, 0, 0);
      n = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 300) : $urandom_range(1, 6);
      send_msg(CMD_RX_COUNT, 0, 16'(n), 0);
      steps = 0;
      while (m_trans != TR_NONE && steps < 3 * n + 4 && steps < 20) begin
        case ($urandom_range(0, 9))
          0: send_msg(CMD_TICK, 0, 0, 0);
          1: send_noise();
          2: send_msg(CMD_RX_ITEM, 16'($urandom), 0, 0);
          default: send_msg(CMD_RX_ITEM, 16'($urandom_range(0, m_rd_total)), 0, 0);
        endcase
        steps++;
      end
    end else if (sel < 8) begin
      n = ($urandom_range(0, 15) == 0) ? 256 : $urandom_range(0, 6);
      send_msg(CMD_START_WRITE, 0, 16'(n), 0);
      for (int i = 0; i < n && i < 8 && m_trans != TR_NONE; i++) begin
        case ($urandom_range(0, 11))
          0: send_msg(CMD_TICK, 0, 0, 0);
          1: send_noise();
          2: ;
          3: send_msg(CMD_RX_REQUEST, 16'($urandom_range(0, n + 1)), 0, 0);
          default: send_msg(CMD_RX_REQUEST, 16'(i), 0, 0);
        endcase
      end
      if (m_trans != TR_NONE)
        send_msg(CMD_RX_ACK, 0, 0, ($urandom_range(0, 4) == 0) ? 8'($urandom) : ACK_ACCEPTED);
    end else begin
      send_msg(CMD_START_CLEAR, 0, 0, 0);
      repeat ($urandom_range(0, 3)) send_msg(CMD_TICK, 0, 0, 0);
      send_msg(CMD_RX_ACK, 0, 0, ($urandom_range(0, 2) == 0) ? ACK_INVALID_SEQ : 8'($urandom));
    end
    if (m_trans != TR_NONE && $urandom_range(0, 1) == 0) send_msg(CMD_CANCEL, 0, 0, 0);
  endtask

  task automatic test_random();
    int goal;
    goal = n_items + 12;
    while (n_items < goal) run_transfer();
    set_regs(8'h00, 1'b0, 16'hFFFF, 16'hFFFF, 8'hFF);
    goal = n_items + 12;
    while (n_items < goal) run_transfer();
    set_regs(8'h3C, 1'b1, 16'd3, 16'd2, 8'd2);
    goal = n_items + 12;
    while (n_items < goal) run_transfer();
  endtask

  task automatic test_backpressure();
    set_regs(8'h11, 1'b0, 16'd1000, 16'd250, 8'd5);
    long_hold_req = 1'b1;
    send_msg(CMD_START_WRITE, 0, 20, 0);
    for (int i = 0; i < 20; i++) send_msg(CMD_RX_REQUEST, 16'(i), 0, 0);
    send_msg(CMD_RX_ACK, 0, 0, ACK_ACCEPTED);
    // hold off until everything has drained
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    wait (expected_msgs.size() == 0);
    send_msg(CMD_START_CLEAR, 0, 0, 0);
    send_msg(CMD_RX_ACK, 0, 0, ACK_ACCEPTED);
  endtask

  task automatic test_no_idle();
    int goal;
    wait_drained();
    no_idle = 1'b1;
    goal = n_items + 20;
    while (n_items < goal) run_transfer();
  endtask

  initial begin
    m_plan = '0; m_quirks = 1'b0; m_ack_to = 16'd1000; m_item_to = 16'd250;
    m_max_retry = 8'd5; m_phase = PH_IDLE; m_trans = TR_NONE; m_retry = '0;
    m_timer = '0; m_timer_on = 1'b0; m_rd_pend = '0; m_wr_pend = '0;
    m_rd_total = '0; m_wr_total = '0;
    n_items = 0; n_msgs = 0; n_errors = 0; no_idle = 1'b0; long_hold_req = 1'b0;
    hold_left = 0; out_burst = 0; quiet_cycles = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_retry_limit();
    test_random();
    test_backpressure();
    test_no_idle();
    wait_drained();
    $display("Sent %0d items (read, write, clear, cancel, timeouts, noise); checked %0d results",
             n_items, n_msgs);
    if (n_errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
